// File: rtl/sbb_pkg.sv
// Package for the separable box blur: constants, register indexes, FSM states and control structs.
`default_nettype none
package sbb_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 7;
    localparam int DEPTH_W        = 16;
    localparam int FRAME_W_W      = 11;
    localparam int FRAME_H_W      = 16;
    localparam int RADIUS_W       = 3;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    localparam logic [FRAME_W_W-1:0] RST_FRAME_WIDTH  = 11'd256;
    localparam logic [FRAME_H_W-1:0] RST_FRAME_HEIGHT = 16'd256;
    localparam logic [RADIUS_W-1:0]  RST_BLUR_RADIUS  = 3'd3;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUR_RADIUS  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_HSET,
        ST_HACC,
        ST_HDIVS,
        ST_HDIV,
        ST_HWRITE,
        ST_ADVANCE,
        ST_VCHECK,
        ST_VSET,
        ST_VADDR,
        ST_VACC,
        ST_VDIVS,
        ST_VDIV,
        ST_VLOAD
    } state_t;

    typedef struct packed {
        logic accept;
        logic h_init;
        logic h_set;
        logic h_acc;
        logic h_write;
        logic div_start_h;
        logic div_start_v;
        logic advance_in;
        logic v_set;
        logic v_acc;
        logic v_load;
    } cmd_t;

    typedef struct packed {
        logic take;
        logic h_job;
        logic h_x_last;
        logic h_j_last;
        logic div_busy;
        logic v_ready;
        logic v_last;
        logic out_full;
    } status_t;

endpackage
`default_nettype wire

// File: rtl/sbb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module sbb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/sbb_div.sv
// Restoring divider, one quotient bit per cycle, for the window averages.
`default_nettype none
module sbb_div #(
    parameter int SW = 21,
    parameter int NW = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [SW-1:0] dividend,
    input  wire logic [NW-1:0] divisor,
    output logic      [SW-1:0] quotient,
    output logic               busy
);

    localparam int CNT_W = $clog2(SW + 1);

    logic [SW-1:0]    q_reg, q_next;
    logic [NW-1:0]    rem_reg, rem_next;
    logic [NW-1:0]    d_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [NW:0]      rem_sh;
    logic             fits;

    always_comb
    begin
        rem_sh    = {rem_reg, q_reg[SW-1]};
        fits      = rem_sh >= {1'b0, d_reg};
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(SW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? NW'(rem_sh - {1'b0, d_reg}) : NW'(rem_sh);
            q_next   = {q_reg[SW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
        begin
            d_reg <= divisor;
        end
    end

    assign quotient = q_reg;
    assign busy     = busy_reg;

endmodule
`default_nettype wire

// File: rtl/sbb_ctrl.sv
// Controller state machine sequencing one item through the filter datapath.
`default_nettype none
module sbb_ctrl
    import sbb_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.take && status.h_job)
                begin
                    cmd.h_init = 1'b1;
                    state_next = ST_HSET;
                end
                else if (status.take)
                begin
                    state_next = ST_ADVANCE;
                end
                else
                begin
                    state_next = ST_VCHECK;
                end
            end
            ST_HSET:
            begin
                cmd.h_set  = 1'b1;
                state_next = ST_HACC;
            end
            ST_HACC:
            begin
                cmd.h_acc = 1'b1;
                if (status.h_j_last)
                begin
                    state_next = ST_HDIVS;
                end
            end
            ST_HDIVS:
            begin
                cmd.div_start_h = 1'b1;
                state_next      = ST_HDIV;
            end
            ST_HDIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_HWRITE;
                end
            end
            ST_HWRITE:
            begin
                cmd.h_write = 1'b1;
                state_next  = status.h_x_last ? ST_ADVANCE : ST_HSET;
            end
            ST_ADVANCE:
            begin
                cmd.advance_in = 1'b1;
                state_next     = ST_VCHECK;
            end
            ST_VCHECK:
            begin
                state_next = status.v_ready ? ST_VSET : ST_IDLE;
            end
            ST_VSET:
            begin
                cmd.v_set  = 1'b1;
                state_next = ST_VADDR;
            end
            ST_VADDR:
            begin
                state_next = ST_VACC;
            end
            ST_VACC:
            begin
                cmd.v_acc  = 1'b1;
                state_next = status.v_last ? ST_VDIVS : ST_VADDR;
            end
            ST_VDIVS:
            begin
                cmd.div_start_v = 1'b1;
                state_next      = ST_VDIV;
            end
            ST_VDIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_VLOAD;
                end
            end
            ST_VLOAD:
            begin
                if (!status.out_full)
                begin
                    cmd.v_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/sbb_datapath.sv
// Datapath: configuration, raster counters, sample window, row store and averaging.
`default_nettype none
module sbb_datapath
    import sbb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    input  wire logic                  in_func,
    input  wire logic [DEPTH_W-1:0]    in_depth,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [DEPTH_W-1:0]         out_depth,
    output logic                       out_last
);

    localparam int WIN  = 2 * MAX_RADIUS + 1;
    localparam int RING = 2 * MAX_RADIUS + 2;
    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int RW   = $clog2(MAX_RADIUS + 1);
    localparam int TW   = $clog2(WIN);
    localparam int GW   = $clog2(RING);
    localparam int NW   = $clog2(RING);
    localparam int SW   = DEPTH_W + NW;
    localparam int AW   = $clog2(RING * MAX_WIDTH);
    localparam int YW   = FRAME_H_W + 1;

    // Configuration.
    logic [FRAME_W_W-1:0] width_reg;
    logic [FRAME_H_W-1:0] height_reg;
    logic [RADIUS_W-1:0]  radius_reg;
    logic [CW-1:0]        w_eff;
    logic [FRAME_H_W-1:0] h_eff;
    logic [RW-1:0]        r_eff;
    logic [CW-1:0]        wm1;
    logic [FRAME_H_W-1:0] hm1;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = CW'(1);
        end
        else if (32'(width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CW'(width_reg);
        end
        h_eff = (height_reg == '0) ? FRAME_H_W'(1) : height_reg;
        r_eff = (32'(radius_reg) > 32'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_reg);
        wm1   = w_eff - 1'b1;
        hm1   = h_eff - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_FRAME_WIDTH;
            height_reg <= RST_FRAME_HEIGHT;
            radius_reg <= RST_BLUR_RADIUS;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data[FRAME_W_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= cfg_data[FRAME_H_W-1:0];
                REG_BLUR_RADIUS:  radius_reg <= cfg_data[RADIUS_W-1:0];
                default:          ;
            endcase
        end
    end

    // Raster counters; the ring indexes follow the rows modulo the ring depth.
    logic [CW-1:0]        in_col_reg, out_col_reg;
    logic [FRAME_H_W-1:0] in_row_reg, out_row_reg;
    logic [GW-1:0]        in_ring_reg, out_ring_reg;
    logic                 take_reg;
    logic                 frame_done;

    // Horizontal pass.
    logic [DEPTH_W-1:0] taps_reg [WIN];
    logic [CW-1:0]      hx_reg, hj_reg, hhi_reg;
    logic [SW-1:0]      hacc_reg;
    logic [NW-1:0]      hcnt_reg;
    logic [CW-1:0]      hx_first, hx_end, hlo;
    logic [CW:0]        hx_plus_r;
    logic [CW-1:0]      hhi;
    logic [TW-1:0]      tap_idx;

    // Vertical pass.
    logic [FRAME_H_W-1:0] vy_reg, vhi_reg;
    logic [GW-1:0]        vring_reg;
    logic [SW-1:0]        vacc_reg;
    logic [NW-1:0]        vcnt_reg;
    logic [YW-1:0]        oy_plus_r;
    logic [FRAME_H_W-1:0] ny, vlo;
    logic [CW:0]          ox_plus_r;
    logic [CW-1:0]        nx;
    logic [GW-1:0]        vdist, vring_lo;

    // Output register.
    logic               out_valid_reg;
    logic [DEPTH_W-1:0] out_depth_reg;
    logic               out_last_reg;

    // Divider and row store.
    logic [SW-1:0]      div_dividend, div_quot;
    logic [NW-1:0]      div_divisor;
    logic               div_busy;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [DEPTH_W-1:0] ram_rdata;

    always_comb
    begin
        hx_first  = (in_col_reg >= CW'(r_eff)) ? in_col_reg - CW'(r_eff) : '0;
        hx_end    = (in_col_reg == wm1) ? in_col_reg : in_col_reg - CW'(r_eff);
        hlo       = (hx_reg >= CW'(r_eff)) ? hx_reg - CW'(r_eff) : '0;
        hx_plus_r = {1'b0, hx_reg} + (CW + 1)'(r_eff);
        hhi       = (hx_plus_r > {1'b0, wm1}) ? wm1 : hx_plus_r[CW-1:0];
        tap_idx   = TW'(in_col_reg - hj_reg);

        oy_plus_r = {1'b0, out_row_reg} + YW'(r_eff);
        ny        = (oy_plus_r > {1'b0, hm1}) ? hm1 : oy_plus_r[FRAME_H_W-1:0];
        ox_plus_r = {1'b0, out_col_reg} + (CW + 1)'(r_eff);
        nx        = (ox_plus_r > {1'b0, wm1}) ? wm1 : ox_plus_r[CW-1:0];
        vlo       = (out_row_reg >= FRAME_H_W'(r_eff)) ? out_row_reg - FRAME_H_W'(r_eff) : '0;
        vdist     = GW'(out_row_reg - vlo);
        vring_lo  = (out_ring_reg >= vdist) ? out_ring_reg - vdist
                                            : GW'(RING) - vdist + out_ring_reg;
        frame_done = (out_row_reg == hm1) && (out_col_reg == wm1);
    end

    assign status.take     = take_reg;
    assign status.h_job    = (in_col_reg == wm1) || (in_col_reg >= CW'(r_eff));
    assign status.h_x_last = hx_reg == hx_end;
    assign status.h_j_last = hj_reg == hhi_reg;
    assign status.div_busy = div_busy;
    assign status.v_ready  = (in_row_reg > ny) || ((in_row_reg == ny) && (in_col_reg > nx));
    assign status.v_last   = vy_reg == vhi_reg;
    assign status.out_full = out_valid_reg;

    // Control state of the counters and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_ring_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_ring_reg  <= '0;
            take_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.accept)
            begin
                take_reg <= !in_func && (in_row_reg < h_eff);
            end
            if (cfg_valid)
            begin
                in_col_reg   <= '0;
                in_row_reg   <= '0;
                in_ring_reg  <= '0;
                out_col_reg  <= '0;
                out_row_reg  <= '0;
                out_ring_reg <= '0;
            end
            else
            begin
                if (cmd.advance_in)
                begin
                    if (in_col_reg == wm1)
                    begin
                        in_col_reg  <= '0;
                        in_row_reg  <= in_row_reg + 1'b1;
                        in_ring_reg <= (in_ring_reg == GW'(RING - 1)) ? '0
                                                                       : in_ring_reg + 1'b1;
                    end
                    else
                    begin
                        in_col_reg <= in_col_reg + 1'b1;
                    end
                end
                if (cmd.v_load)
                begin
                    out_valid_reg <= 1'b1;
                    if (frame_done)
                    begin
                        // The last pixel of the frame sends every counter back to the start.
                        in_col_reg   <= '0;
                        in_row_reg   <= '0;
                        in_ring_reg  <= '0;
                        out_col_reg  <= '0;
                        out_row_reg  <= '0;
                        out_ring_reg <= '0;
                    end
                    else if (out_col_reg == wm1)
                    begin
                        out_col_reg  <= '0;
                        out_row_reg  <= out_row_reg + 1'b1;
                        out_ring_reg <= (out_ring_reg == GW'(RING - 1)) ? '0
                                                                         : out_ring_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_reg <= out_col_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && !in_func && (in_row_reg < h_eff))
        begin
            taps_reg[0] <= in_depth;
            for (int i = 1; i < WIN; i++)
            begin
                taps_reg[i] <= taps_reg[i-1];
            end
        end
        if (cmd.h_init)
        begin
            hx_reg <= hx_first;
        end
        else if (cmd.h_write)
        begin
            hx_reg <= hx_reg + 1'b1;
        end
        if (cmd.h_set)
        begin
            hj_reg   <= hlo;
            hhi_reg  <= hhi;
            hacc_reg <= '0;
            hcnt_reg <= NW'(hhi - hlo + 1'b1);
        end
        else if (cmd.h_acc)
        begin
            hacc_reg <= hacc_reg + SW'(taps_reg[tap_idx]);
            hj_reg   <= hj_reg + 1'b1;
        end
        if (cmd.v_set)
        begin
            vy_reg    <= vlo;
            vhi_reg   <= ny;
            vring_reg <= vring_lo;
            vacc_reg  <= '0;
            vcnt_reg  <= NW'(ny - vlo + 1'b1);
        end
        else if (cmd.v_acc)
        begin
            vacc_reg  <= vacc_reg + SW'(ram_rdata);
            vy_reg    <= vy_reg + 1'b1;
            vring_reg <= (vring_reg == GW'(RING - 1)) ? '0 : vring_reg + 1'b1;
        end
        if (cmd.v_load)
        begin
            out_depth_reg <= div_quot[DEPTH_W-1:0];
            out_last_reg  <= frame_done;
        end
    end

    assign div_dividend = cmd.div_start_h ? hacc_reg : vacc_reg;
    assign div_divisor  = cmd.div_start_h ? hcnt_reg : vcnt_reg;

    sbb_div #(
        .SW (SW),
        .NW (NW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start_h || cmd.div_start_v),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .busy     (div_busy)
    );

    assign ram_waddr = AW'(in_ring_reg) * AW'(MAX_WIDTH) + AW'(hx_reg);
    assign ram_raddr = AW'(vring_reg) * AW'(MAX_WIDTH) + AW'(out_col_reg);

    sbb_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (RING * MAX_WIDTH)
    ) u_row_store (
        .clk   (clk),
        .we    (cmd.h_write),
        .waddr (ram_waddr),
        .wdata (div_quot[DEPTH_W-1:0]),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_depth = out_depth_reg;
    assign out_last  = out_last_reg;

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.v_load |-> !out_valid_reg)
        else $error("result loaded over an untaken result");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_start_h || cmd.div_start_v) |-> !div_busy)
        else $error("divider started while busy");
    a_write_col: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.h_write |-> (hx_reg <= wm1))
        else $error("row store written beyond the row");
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_depth_reg)))
        else $error("pending result changed before its transfer");
`endif

endmodule
`default_nettype wire

// File: rtl/separable_box_blur_unit.sv
// Top level of the separable box blur: stream ports, configuration port, controller and datapath.
//
// Usage: depth samples (Q0.16) enter in raster order on the s_axis channel; tuser set
// marks a drain tick that carries no sample. Averaged samples leave in raster order on
// m_axis, tlast marking the last pixel of the frame. The cfg channel writes frame width
// (index 0), frame height (index 1) and blur radius (index 2); any write restarts the
// frame and is always taken.
// Each item is handled to completion before the next transfer is accepted. An item
// passes the check state, then, for each horizontal result it completes, sums the
// (hi-lo+1) window taps, divides and writes the average to the row store; a sample
// that is taken in then advances the input counters; when an output is due, the
// block reads one window row at a time from the row store, sums, divides and loads
// the output register. The shared restoring divider (one quotient bit per cycle)
// and the single read port of the row store set the pace of these steps.
// Reset clears the raster counters and restores the default registers (256 x 256, radius 3).
// The row store needs no clearing: every entry is written before it is read.
// A finished result waits in the output register; while the receiver stalls, the block
// still takes the next item and stalls only when a further result is ready to load.
`default_nettype none
module separable_box_blur_unit
    import sbb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [DEPTH_W-1:0]    s_axis_tdata,  // [15:0] depth_in
    input  wire logic                  s_axis_tuser,  // [0] func
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [DEPTH_W-1:0]         m_axis_tdata,  // [15:0] depth_out
    output logic                       m_axis_tlast,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    sbb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sbb_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_func   (s_axis_tuser),
        .in_depth  (s_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_depth (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire
